FILE: hw/rtl/idt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idt_pkg
// Shared constants, codes and types for the indent/dedent tracker.
// ----------------------------------------------------------------------------
package idt_pkg;

  // Sizing
  localparam int MAX_INDENT = 1024;
  localparam int MAX_LEVELS = 32;
  localparam int IDX_W      = $clog2(MAX_INDENT);
  localparam int LEN_W      = $clog2(MAX_INDENT + 1);
  localparam int LVL_AW     = $clog2(MAX_LEVELS);
  localparam int LVL_CW     = $clog2(MAX_LEVELS + 1);

  // Input operation codes
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_BREAK = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_NEWLINE = 2'd0;
  localparam logic [1:0] KIND_INDENT  = 2'd1;
  localparam logic [1:0] KIND_DEDENT  = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Level stack sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT
  } stk_state_t;

  // Summary of the current whitespace run
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             bad;   // mismatch against stack or overflow
  } run_info_t;

endpackage
`default_nettype wire

FILE: hw/rtl/idt_run_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idt_run_tracker
// Follows the current whitespace run: holds the indent character memory,
// compares each run character against the stored stack characters and
// writes characters that extend past the stack.
// ----------------------------------------------------------------------------
module idt_run_tracker import idt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_go,
  input  logic             clear_go,
  input  logic             tab,
  input  logic [LEN_W-1:0] indent_length,
  output run_info_t        run
);

  logic             chars_mem [MAX_INDENT];
  logic             rd_bit;
  logic [LEN_W-1:0] run_length;
  logic             run_mismatch;
  logic             run_overflow;
  logic             pend_valid;
  logic             pend_tab;
  logic             pend_mis;
  logic [IDX_W-1:0] addr;
  logic             room;
  logic             compare;

  assign addr     = run_length[IDX_W-1:0];
  assign room     = run_length < LEN_W'(MAX_INDENT);
  assign compare  = run_length < indent_length;
  // compare issued last cycle resolves against the registered read data
  assign pend_mis = pend_valid && (rd_bit != pend_tab);

  // Character memory: write past the stack, read under it
  always_ff @(posedge clk) begin
    if (char_go && room && !compare) begin
      chars_mem[addr] <= tab;
    end
    rd_bit <= chars_mem[addr];
  end

  // Run state
  always_ff @(posedge clk) begin
    if (rst || clear_go) begin
      run_length   <= '0;
      run_mismatch <= 1'b0;
      run_overflow <= 1'b0;
      pend_valid   <= 1'b0;
      pend_tab     <= 1'b0;
    end else begin
      run_mismatch <= run_mismatch | pend_mis;
      pend_valid   <= char_go && room && compare;
      pend_tab     <= tab;
      if (char_go) begin
        if (room) begin
          run_length <= run_length + LEN_W'(1);
        end else begin
          run_overflow <= 1'b1;
        end
      end
    end
  end

  assign run.len = run_length;
  assign run.bad = run_overflow | run_mismatch | pend_mis;

endmodule
`default_nettype wire

FILE: hw/rtl/idt_level_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idt_level_stack
// Holds the level end memory and the stack totals. On a run close it decides
// newline, indent, dedent burst or error, scans levels down for dedents and
// drives the result register.
// ----------------------------------------------------------------------------
module idt_level_stack import idt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             close_go,
  input  run_info_t        run,
  input  logic [15:0]      line,
  input  logic [15:0]      column,
  output logic             busy,
  output logic [LEN_W-1:0] indent_length,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      token_line,
  output logic [15:0]      token_column,
  output logic             last
);

  logic [LEN_W-1:0]  level_mem [MAX_LEVELS];
  logic [LEN_W-1:0]  rd_data;
  logic [LVL_AW-1:0] rd_addr;

  stk_state_t        state, state_next;
  logic [LEN_W-1:0]  len_q;
  logic              bad_q;
  logic [15:0]       line_q;
  logic [15:0]       col_q;
  logic [LVL_CW-1:0] level_count, level_count_next;
  logic [LEN_W-1:0]  indent_length_next;
  logic [LVL_CW-1:0] scan_k, scan_k_next;
  logic [LVL_CW-1:0] pops, pops_next;
  logic [LVL_CW-1:0] dedent_left, dedent_left_next;
  logic              nl_pending, nl_pending_next;
  logic [1:0]        em_kind, em_kind_next;
  logic              lvl_we;
  logic              out_load;
  logic [1:0]        emit_kind;
  logic              emit_last;
  logic [LEN_W-1:0]  scan_cur;

  assign rd_addr  = LVL_AW'(scan_k - LVL_CW'(2));
  assign scan_cur = (scan_k != '0) ? rd_data : '0;
  assign busy     = (state != ST_IDLE);

  // Level end memory
  always_ff @(posedge clk) begin
    if (lvl_we) begin
      level_mem[level_count[LVL_AW-1:0]] <= len_q;
    end
    rd_data <= level_mem[rd_addr];
  end

  // Next state and control
  always_comb begin
    state_next         = state;
    level_count_next   = level_count;
    indent_length_next = indent_length;
    scan_k_next        = scan_k;
    pops_next          = pops;
    dedent_left_next   = dedent_left;
    nl_pending_next    = nl_pending;
    em_kind_next       = em_kind;
    lvl_we             = 1'b0;
    out_load           = 1'b0;
    emit_kind          = nl_pending ? em_kind : KIND_DEDENT;
    emit_last          = nl_pending ? (dedent_left == '0)
                                    : (dedent_left == LVL_CW'(1));
    case (state)
      ST_IDLE: begin
        if (close_go) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        nl_pending_next  = 1'b1;
        dedent_left_next = '0;
        if (bad_q) begin
          em_kind_next = KIND_ERROR;
          state_next   = ST_EMIT;
        end else if (len_q == indent_length) begin
          em_kind_next = KIND_NEWLINE;
          state_next   = ST_EMIT;
        end else if (len_q > indent_length) begin
          if (level_count >= LVL_CW'(MAX_LEVELS)) begin
            em_kind_next = KIND_ERROR;
          end else begin
            lvl_we             = 1'b1;
            level_count_next   = level_count + LVL_CW'(1);
            indent_length_next = len_q;
            em_kind_next       = KIND_INDENT;
          end
          state_next = ST_EMIT;
        end else begin
          scan_k_next = level_count;
          pops_next   = '0;
          state_next  = ST_SCAN_RD;
        end
      end
      // pop one level; read the end of the level below it
      ST_SCAN_RD: begin
        scan_k_next = scan_k - LVL_CW'(1);
        pops_next   = pops + LVL_CW'(1);
        state_next  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if ((scan_cur > len_q) && (scan_k != '0)) begin
          state_next = ST_SCAN_RD;
        end else if (scan_cur != len_q) begin
          em_kind_next = KIND_ERROR;
          state_next   = ST_EMIT;
        end else begin
          level_count_next   = scan_k;
          indent_length_next = scan_cur;
          em_kind_next       = KIND_NEWLINE;
          dedent_left_next   = pops;
          state_next         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (nl_pending) begin
            nl_pending_next = 1'b0;
          end else begin
            dedent_left_next = dedent_left - LVL_CW'(1);
          end
          if (emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      level_count   <= '0;
      indent_length <= '0;
      scan_k        <= '0;
      pops          <= '0;
      dedent_left   <= '0;
      nl_pending    <= 1'b0;
      em_kind       <= KIND_NEWLINE;
    end else begin
      state         <= state_next;
      level_count   <= level_count_next;
      indent_length <= indent_length_next;
      scan_k        <= scan_k_next;
      pops          <= pops_next;
      dedent_left   <= dedent_left_next;
      nl_pending    <= nl_pending_next;
      em_kind       <= em_kind_next;
    end
  end

  // Closing transaction capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && close_go) begin
      len_q  <= run.len;
      bad_q  <= run.bad;
      line_q <= line;
      col_q  <= column;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind         <= emit_kind;
      token_line   <= line_q;
      token_column <= col_q;
      last         <= emit_last;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/indent_dedent_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indent_dedent_tracker_top
// Indent/dedent tracker: compares leading whitespace runs against a stack of
// exact indent strings and returns newline, indent, dedent or error results.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid / in_ready    op, is_tab, in_brackets, line, column
//  output   out_valid / out_ready  kind, token_line, token_column, last
//
//  Whitespace, line break and bracketed end transactions are taken one per
//  cycle while ready; a character compare completes against the memory read
//  in the next cycle and is forwarded to a run end arriving right behind it.
//  A run close holds in_ready low for a decide state, a level end read and a
//  compare state per popped level, then one result per cycle while out_ready.
//  The last result may sit in the output register while new input flows.
//  Reset is synchronous; no memory clearing pass is run.
// ----------------------------------------------------------------------------
module indent_dedent_tracker_top import idt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic        is_tab,
  input  logic        in_brackets,
  input  logic [15:0] line,
  input  logic [15:0] column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] token_line,
  output logic [15:0] token_column,
  output logic        last
);

  logic             busy;
  logic             accept;
  logic             char_go;
  logic             clear_go;
  logic             close_go;
  logic [LEN_W-1:0] indent_length;
  run_info_t        run;

  // Input decode
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign char_go  = accept && (op == OP_CHAR);
  assign clear_go = accept && ((op == OP_BREAK) || (op == OP_END));
  assign close_go = accept && (op == OP_END) && !in_brackets;

  idt_run_tracker u_run (
    .clk           (clk),
    .rst           (rst),
    .char_go       (char_go),
    .clear_go      (clear_go),
    .tab           (is_tab),
    .indent_length (indent_length),
    .run           (run)
  );

  idt_level_stack u_stack (
    .clk           (clk),
    .rst           (rst),
    .close_go      (close_go),
    .run           (run),
    .line          (line),
    .column        (column),
    .busy          (busy),
    .indent_length (indent_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .token_line    (token_line),
    .token_column  (token_column),
    .last          (last)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/indent_dedent_tracker_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indent_dedent_tracker_checker
// Port level checks on result sequencing and input hold-off.
// ----------------------------------------------------------------------------
module indent_dedent_tracker_checker import idt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  op,
  input logic        in_brackets,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] token_line,
  input logic        last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(token_line)
      && $stable(last))
    else $error("result changed while stalled");

  // a run close blocks input on the next cycle
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_END) && !in_brackets |=> !in_ready)
    else $error("input accepted during run close");

  // error and indent stand alone
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((kind == KIND_ERROR) || (kind == KIND_INDENT)) |-> last)
    else $error("error or indent not the last result");

  // no input while a burst is unfinished
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input ready during result burst");

  // a taken non-final result is followed at once by the next
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("gap inside result burst");

endmodule

bind indent_dedent_tracker_top indent_dedent_tracker_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .op          (op),
  .in_brackets (in_brackets),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .token_line  (token_line),
  .last        (last)
);
`default_nettype wire
